### hdl/riq_pkg.sv
package riq_pkg;

  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned ENTRY_W = TAG_W + TIME_W;

  localparam logic [CFG_IDX_W-1:0] REG_ROUTER_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SERVICE_DELAY  = 1'b1;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_SWITCH = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE      = 3'd0,
    KIND_DELIVERED = 3'd1,
    KIND_ENQUEUED  = 3'd2,
    KIND_DROPPED   = 3'd3,
    KIND_SWITCHED  = 3'd4
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctl_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } dp_status_t;

endpackage

### hdl/riq_ctrl.sv
module riq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output riq_pkg::ctl_cmd_t cmd
);
  import riq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy        = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd.capture = start;
      end
      ST_EXEC: begin
        busy        = 1'b1;
        cmd.execute = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

### hdl/riq_dp.sv
module riq_dp #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  riq_pkg::ctl_cmd_t             cmd,
  output riq_pkg::dp_status_t           status,
  input  logic                          cfg_we,
  input  logic [riq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [riq_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_op,
  input  logic [riq_pkg::TAG_W-1:0]     in_pkt_tag,
  input  logic [riq_pkg::ADDR_W-1:0]    in_pkt_destination,
  input  logic [riq_pkg::TIME_W-1:0]    in_pkt_time,
  input  logic [riq_pkg::TIME_W-1:0]    in_current_time,
  output logic                          out_valid,
  output logic [riq_pkg::KIND_W-1:0]    out_result_kind,
  output logic [riq_pkg::TAG_W-1:0]     out_result_tag,
  output logic [riq_pkg::TIME_W-1:0]    out_result_time,
  output logic [riq_pkg::CNT_W-1:0]     out_received_count,
  output logic [riq_pkg::CNT_W-1:0]     out_dropped_count,
  output logic [riq_pkg::CNT_W-1:0]     out_switched_count
);
  import riq_pkg::*;

  localparam int unsigned IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_LVL = FILL_W'(QUEUE_DEPTH);

  // configuration
  logic [ADDR_W-1:0] router_address_r;
  logic [CFG_W-1:0]  service_delay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      router_address_r <= '0;
      service_delay_r  <= CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROUTER_ADDRESS: router_address_r <= cfg_data;
        REG_SERVICE_DELAY:  service_delay_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // captured item
  logic              op_r;
  logic [TAG_W-1:0]  tag_r;
  logic [ADDR_W-1:0] dest_r;
  logic [TIME_W-1:0] ptime_r;
  logic [TIME_W-1:0] now_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_op;
      tag_r   <= in_pkt_tag;
      dest_r  <= in_pkt_destination;
      ptime_r <= in_pkt_time;
      now_r   <= in_current_time;
    end
  end

  // queue state
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  // head entry is read while the item is captured
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_data_r <= mem[head_r];
    end
  end

  logic [TIME_W:0]    ready_sum;
  logic [TIME_W-1:0]  ready_time;
  logic [TAG_W-1:0]   head_tag;
  logic [TIME_W-1:0]  head_time;
  logic               q_empty, q_full;
  logic               do_deliver, do_enq, do_drop, do_switch;

  assign q_empty = (fill_r == '0);
  assign q_full  = (fill_r == FULL_LVL);
  assign status.empty = q_empty;
  assign status.full  = q_full;

  assign ready_sum  = {1'b0, ptime_r} + {{(TIME_W + 1 - CFG_W){1'b0}}, service_delay_r};
  assign ready_time = ready_sum[TIME_W] ? {TIME_W{1'b1}} : ready_sum[TIME_W-1:0];
  assign head_tag   = rd_data_r[ENTRY_W-1:TIME_W];
  assign head_time  = rd_data_r[TIME_W-1:0];

  assign do_deliver = (op_r == OP_ARRIVE) && (dest_r == router_address_r);
  assign do_enq     = (op_r == OP_ARRIVE) && !do_deliver && !q_full;
  assign do_drop    = (op_r == OP_ARRIVE) && !do_deliver && q_full;
  assign do_switch  = (op_r == OP_SWITCH) && !q_empty && (head_time <= now_r);

  always_ff @(posedge clk) begin
    if (cmd.execute && do_enq) begin
      mem[tail_r] <= {tag_r, ready_time};
    end
  end

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    if (cmd.execute) begin
      if (do_enq) begin
        tail_nxt = (tail_r == LAST_IDX) ? '0 : tail_r + IDX_W'(1);
        fill_nxt = fill_r + FILL_W'(1);
      end
      if (do_switch) begin
        head_nxt = (head_r == LAST_IDX) ? '0 : head_r + IDX_W'(1);
        fill_nxt = fill_r - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
    end
  end

  // tallies, saturating
  logic [CNT_W-1:0] received_r, dropped_r, switched_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      received_r <= '0;
      dropped_r  <= '0;
      switched_r <= '0;
    end else if (cmd.execute) begin
      if (do_deliver && (received_r != {CNT_W{1'b1}})) begin
        received_r <= received_r + CNT_W'(1);
      end
      if (do_drop && (dropped_r != {CNT_W{1'b1}})) begin
        dropped_r <= dropped_r + CNT_W'(1);
      end
      if (do_switch && (switched_r != {CNT_W{1'b1}})) begin
        switched_r <= switched_r + CNT_W'(1);
      end
    end
  end

  // result register
  logic              valid_r;
  kind_t             kind_r, kind_nxt;
  logic [TAG_W-1:0]  rtag_r, rtag_nxt;
  logic [TIME_W-1:0] rtime_r, rtime_nxt;

  always_comb begin
    kind_nxt  = KIND_NONE;
    rtag_nxt  = '0;
    rtime_nxt = '0;
    if (do_deliver) begin
      kind_nxt  = KIND_DELIVERED;
      rtag_nxt  = tag_r;
      rtime_nxt = ptime_r;
    end else if (do_enq) begin
      kind_nxt  = KIND_ENQUEUED;
      rtag_nxt  = tag_r;
      rtime_nxt = ready_time;
    end else if (do_drop) begin
      kind_nxt  = KIND_DROPPED;
      rtag_nxt  = tag_r;
      rtime_nxt = ptime_r;
    end else if (do_switch) begin
      kind_nxt  = KIND_SWITCHED;
      rtag_nxt  = head_tag;
      rtime_nxt = head_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.execute;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      kind_r  <= kind_nxt;
      rtag_r  <= rtag_nxt;
      rtime_r <= rtime_nxt;
    end
  end

  assign out_valid          = valid_r;
  assign out_result_kind    = kind_r;
  assign out_result_tag     = rtag_r;
  assign out_result_time    = rtime_r;
  assign out_received_count = received_r;
  assign out_dropped_count  = dropped_r;
  assign out_switched_count = switched_r;

endmodule

### hdl/router_input_queue_core.sv
// Drop-tail input queue of one router port. An item is taken when start is high and busy is
// low; busy then stays high for one cycle and the result appears on the out_ ports, marked
// by out_valid, for exactly one cycle after that, so a new item may be started in the same
// cycle its predecessor's result is shown. An item passes through the registered read of the
// queue head from the packet memory followed by the decide-and-update step. Results cannot be
// held off by the receiver: out_valid is a strobe and must be taken when it is high. The tally
// outputs stay valid between strobes. Configuration writes take effect at once and belong to
// idle periods.
module router_input_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [riq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [riq_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [riq_pkg::TAG_W-1:0]     in_pkt_tag,
  input  logic [riq_pkg::ADDR_W-1:0]    in_pkt_destination,
  input  logic [riq_pkg::TIME_W-1:0]    in_pkt_time,
  input  logic [riq_pkg::TIME_W-1:0]    in_current_time,
  output logic                          out_valid,
  output logic [riq_pkg::KIND_W-1:0]    out_result_kind,
  output logic [riq_pkg::TAG_W-1:0]     out_result_tag,
  output logic [riq_pkg::TIME_W-1:0]    out_result_time,
  output logic [riq_pkg::CNT_W-1:0]     out_received_count,
  output logic [riq_pkg::CNT_W-1:0]     out_dropped_count,
  output logic [riq_pkg::CNT_W-1:0]     out_switched_count
);
  import riq_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  riq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  riq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_op              (in_op),
    .in_pkt_tag         (in_pkt_tag),
    .in_pkt_destination (in_pkt_destination),
    .in_pkt_time        (in_pkt_time),
    .in_current_time    (in_current_time),
    .out_valid          (out_valid),
    .out_result_kind    (out_result_kind),
    .out_result_tag     (out_result_tag),
    .out_result_time    (out_result_time),
    .out_received_count (out_received_count),
    .out_dropped_count  (out_dropped_count),
    .out_switched_count (out_switched_count)
  );

  // every started item raises busy and then yields a result strobe
  a_start_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy ##1 out_valid)
    else $error("transfer did not produce a result");

  a_strobe_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without work");

  a_switch_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind == KIND_SWITCHED)) |-> $past(!status.empty))
    else $error("switched out of an empty queue");

  a_enq_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind == KIND_ENQUEUED)) |-> $past(!status.full))
    else $error("enqueued into a full queue");

  a_empty_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(status.empty && status.full))
    else $error("queue both empty and full");

endmodule

### tb/tb_router_input_queue_core.sv
module tb_router_input_queue_core;
  import riq_pkg::*;

  localparam int QDEPTH         = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic              op;
    logic [TAG_W-1:0]  tag;
    logic [ADDR_W-1:0] dest;
    logic [TIME_W-1:0] ptime;
    logic [TIME_W-1:0] now;
  } pkt_cmd_t;

  typedef struct {
    kind_t             kind;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] rtime;
    logic [CNT_W-1:0]  received;
    logic [CNT_W-1:0]  dropped;
    logic [CNT_W-1:0]  switched;
  } outcome_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 start;
  logic                 busy;
  logic                 in_op;
  logic [TAG_W-1:0]     in_pkt_tag;
  logic [ADDR_W-1:0]    in_pkt_destination;
  logic [TIME_W-1:0]    in_pkt_time;
  logic [TIME_W-1:0]    in_current_time;
  logic                 out_valid;
  logic [KIND_W-1:0]    out_result_kind;
  logic [TAG_W-1:0]     out_result_tag;
  logic [TIME_W-1:0]    out_result_time;
  logic [CNT_W-1:0]     out_received_count;
  logic [CNT_W-1:0]     out_dropped_count;
  logic [CNT_W-1:0]     out_switched_count;

  router_input_queue_core #(.QUEUE_DEPTH(QDEPTH)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_pkt_tag         (in_pkt_tag),
    .in_pkt_destination (in_pkt_destination),
    .in_pkt_time        (in_pkt_time),
    .in_current_time    (in_current_time),
    .out_valid          (out_valid),
    .out_result_kind    (out_result_kind),
    .out_result_tag     (out_result_tag),
    .out_result_time    (out_result_time),
    .out_received_count (out_received_count),
    .out_dropped_count  (out_dropped_count),
    .out_switched_count (out_switched_count)
  );

  // shadow of the queue, tallies and registers
  logic [TAG_W-1:0]  shadow_tag [QDEPTH];
  logic [TIME_W-1:0] shadow_ready [QDEPTH];
  int unsigned       shadow_head = 0;
  int unsigned       shadow_tail = 0;
  int unsigned       shadow_fill = 0;
  logic [CNT_W-1:0]  rx_tally = '0;
  logic [CNT_W-1:0]  drop_tally = '0;
  logic [CNT_W-1:0]  sw_tally = '0;
  logic [ADDR_W-1:0] my_address = '0;
  logic [CFG_W-1:0]  svc_delay = 16'd1;

  outcome_t          pending_outcomes [$];
  outcome_t          want;
  int                error_count = 0;
  int                idle_cycles = 0;
  logic [TIME_W-1:0] traffic_clock = '0;

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [CNT_W-1:0] sat_bump(logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic outcome_t route_packet(pkt_cmd_t c);
    outcome_t         o;
    logic [TIME_W:0]  sum;
    o.kind = KIND_NONE;
    o.tag = '0;
    o.rtime = '0;
    if (c.op == OP_ARRIVE) begin
      o.tag = c.tag;
      if (c.dest == my_address) begin
        rx_tally = sat_bump(rx_tally);
        o.kind = KIND_DELIVERED;
        o.rtime = c.ptime;
      end else if (shadow_fill < QDEPTH) begin
        sum = c.ptime + svc_delay;
        o.rtime = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        shadow_tag[shadow_tail] = c.tag;
        shadow_ready[shadow_tail] = o.rtime;
        shadow_tail = (shadow_tail + 1) % QDEPTH;
        shadow_fill++;
        o.kind = KIND_ENQUEUED;
      end else begin
        drop_tally = sat_bump(drop_tally);
        o.kind = KIND_DROPPED;
        o.rtime = c.ptime;
      end
    end else if (shadow_fill != 0 && shadow_ready[shadow_head] <= c.now) begin
      o.tag = shadow_tag[shadow_head];
      o.rtime = shadow_ready[shadow_head];
      shadow_head = (shadow_head + 1) % QDEPTH;
      shadow_fill--;
      sw_tally = sat_bump(sw_tally);
      o.kind = KIND_SWITCHED;
    end
    o.received = rx_tally;
    o.dropped = drop_tally;
    o.switched = sw_tally;
    return o;
  endfunction

  function automatic pkt_cmd_t pkt(logic op, logic [TAG_W-1:0] tag, logic [ADDR_W-1:0] dest,
                                   logic [TIME_W-1:0] ptime, logic [TIME_W-1:0] now);
    pkt_cmd_t c;
    c.op = op;
    c.tag = tag;
    c.dest = dest;
    c.ptime = ptime;
    c.now = now;
    return c;
  endfunction

  // mostly times that track a running clock so that heads become ready; some raw values
  function automatic pkt_cmd_t make_cmd(int arrive_pct);
    pkt_cmd_t c;
    int       r;
    c.op = ($urandom_range(0, 99) < arrive_pct) ? OP_ARRIVE : OP_SWITCH;
    c.tag = TAG_W'($urandom);
    c.dest = ADDR_W'($urandom);
    c.ptime = $urandom;
    c.now = $urandom;
    r = $urandom_range(0, 99);
    if (r < 88) begin
      traffic_clock = traffic_clock + $urandom_range(0, 3000);
      c.ptime = traffic_clock + $urandom_range(0, 1000);
      c.now = traffic_clock;
    end else if (r < 94) begin
      // near the top so the ready time saturates
      c.ptime = 32'hFFFF_FFFF - $urandom_range(0, 70000);
      c.now = 32'hFFFF_FFFF - $urandom_range(0, 3);
    end
    if ($urandom_range(0, 3) == 0) c.dest = my_address;
    if ($urandom_range(0, 49) == 0) c.now = '1;
    return c;
  endfunction

  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic pause(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // start stays high on return; the block is busy for the next edge anyway
  task automatic send_cmd(pkt_cmd_t c);
    start <= 1'b1;
    in_op <= c.op;
    in_pkt_tag <= c.tag;
    in_pkt_destination <= c.dest;
    in_pkt_time <= c.ptime;
    in_current_time <= c.now;
    while (busy) @(negedge clk);
    pending_outcomes.push_back(route_packet(c));
    @(negedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (pending_outcomes.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_ROUTER_ADDRESS) my_address = val;
    else svc_delay = val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(logic [CFG_W-1:0] addr, logic [CFG_W-1:0] delay);
    drain_results();
    write_reg(REG_ROUTER_ADDRESS, addr);
    write_reg(REG_SERVICE_DELAY, delay);
  endtask

  task automatic run_traffic(int count, int arrive_pct, bit with_gaps);
    int gap;
    for (int i = 0; i < count; i++) begin
      // halfway through, the sender holds off until the block has answered everything
      if (i == count / 2) drain_results();
      gap = with_gaps ? gap_cycles() : 0;
      pause(gap);
      send_cmd(make_cmd(arrive_pct));
    end
  endtask

  task automatic test_directed_ops();
    // reset values: address 0, delay 1
    send_cmd(pkt(OP_SWITCH, TAG_W'($urandom), ADDR_W'($urandom), $urandom, $urandom));
    send_cmd(pkt(OP_ARRIVE, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, $urandom));
    send_cmd(pkt(OP_ARRIVE, 16'h0000, 16'h0000, 32'h0000_0000, $urandom));
    send_cmd(pkt(OP_ARRIVE, 16'h1234, 16'hFFFF, 32'hFFFF_FFFF, $urandom));
    send_cmd(pkt(OP_SWITCH, TAG_W'($urandom), ADDR_W'($urandom), $urandom, 32'hFFFF_FFFE));
    send_cmd(pkt(OP_SWITCH, TAG_W'($urandom), ADDR_W'($urandom), $urandom, 32'hFFFF_FFFF));
    send_cmd(pkt(OP_ARRIVE, 16'hFFFF, 16'h0001, 32'h0000_0000, 32'hFFFF_FFFF));
    send_cmd(pkt(OP_SWITCH, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000));
    send_cmd(pkt(OP_SWITCH, TAG_W'($urandom), ADDR_W'($urandom), $urandom, 32'h0000_0001));
    send_cmd(pkt(OP_SWITCH, TAG_W'($urandom), ADDR_W'($urandom), $urandom, 32'hFFFF_FFFF));
    drain_results();
  endtask

  task automatic test_full_queue();
    for (int i = 0; i < QDEPTH; i++)
      send_cmd(pkt(OP_ARRIVE, TAG_W'($urandom), ADDR_W'($urandom_range(1, 16'hFFFF)),
                   $urandom, $urandom));
    // delivery still goes through on a full queue, anything else is dropped
    send_cmd(pkt(OP_ARRIVE, TAG_W'($urandom), 16'h0000, $urandom, $urandom));
    send_cmd(pkt(OP_ARRIVE, TAG_W'($urandom), 16'hFFFF, $urandom, $urandom));
    drain_results();
  endtask

  task automatic test_delay_extremes();
    configure(CFG_W'($urandom), 16'h0000);
    run_traffic(300, 50, 1'b1);
    configure(CFG_W'($urandom), 16'hFFFF);
    run_traffic(300, 60, 1'b0);
  endtask

  task automatic test_address_extremes();
    configure(16'hFFFF, CFG_W'($urandom_range(0, 8)));
    run_traffic(300, 70, 1'b1);
    configure(16'h0000, 16'd1);
    run_traffic(300, 40, 1'b1);
  endtask

  task automatic test_random_mix();
    repeat (4) begin
      configure(CFG_W'($urandom),
                CFG_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, 2000) : $urandom));
      run_traffic(200, $urandom_range(30, 70), $urandom_range(0, 3) != 0);
    end
  endtask

  task automatic report_mismatch(string what);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%s: expected kind %0d tag %h time %h rx %0d drop %0d sw %0d",
               what, want.kind, want.tag, want.rtime, want.received, want.dropped,
               want.switched);
      $display("  got kind %0d tag %h time %h rx %0d drop %0d sw %0d",
               out_result_kind, out_result_tag, out_result_time,
               out_received_count, out_dropped_count, out_switched_count);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_outcomes.size() == 0) begin
        want = '{KIND_NONE, '0, '0, '0, '0, '0};
        report_mismatch("result with nothing pending");
      end else begin
        want = pending_outcomes.pop_front();
        if (out_result_kind !== want.kind || out_result_tag !== want.tag ||
            out_result_time !== want.rtime || out_received_count !== want.received ||
            out_dropped_count !== want.dropped || out_switched_count !== want.switched)
          report_mismatch("result mismatch");
      end
    end
  end

  // counts cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("router_input_queue_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_op = OP_ARRIVE;
    in_pkt_tag = '0;
    in_pkt_destination = '0;
    in_pkt_time = '0;
    in_current_time = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_ops();
    test_full_queue();
    test_delay_extremes();
    test_address_extremes();
    test_random_mix();

    drain_results();
    repeat (6) @(negedge clk);
    error_count += pending_outcomes.size();
    if (error_count == 0) begin
      $display("router_input_queue_core verification clean");
    end else begin
      $display("router_input_queue_core verification failed");
    end
    $finish;
  end

endmodule
